>>> rtl/aluf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aluf_pkg
// Shared operation codes and request/result types for the accumulator ALU.
// ----------------------------------------------------------------------------
package aluf_pkg;

  localparam int unsigned FuncW   = 5;
  localparam int unsigned WordW   = 16;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 24;

  localparam logic [FuncW-1:0] FuncAdd  = 5'd0;
  localparam logic [FuncW-1:0] FuncAdc  = 5'd1;
  localparam logic [FuncW-1:0] FuncSub  = 5'd2;
  localparam logic [FuncW-1:0] FuncSbc  = 5'd3;
  localparam logic [FuncW-1:0] FuncCmp  = 5'd4;
  localparam logic [FuncW-1:0] FuncAnd  = 5'd5;
  localparam logic [FuncW-1:0] FuncOr   = 5'd6;
  localparam logic [FuncW-1:0] FuncEor  = 5'd7;
  localparam logic [FuncW-1:0] FuncBit  = 5'd8;
  localparam logic [FuncW-1:0] FuncLsr  = 5'd9;
  localparam logic [FuncW-1:0] FuncAsr  = 5'd10;
  localparam logic [FuncW-1:0] FuncAsl  = 5'd11;
  localparam logic [FuncW-1:0] FuncRor  = 5'd12;
  localparam logic [FuncW-1:0] FuncRol  = 5'd13;
  localparam logic [FuncW-1:0] FuncNeg  = 5'd14;
  localparam logic [FuncW-1:0] FuncCom  = 5'd15;
  localparam logic [FuncW-1:0] FuncInc  = 5'd16;
  localparam logic [FuncW-1:0] FuncDec  = 5'd17;
  localparam logic [FuncW-1:0] FuncClr  = 5'd18;
  localparam logic [FuncW-1:0] FuncTst  = 5'd19;
  localparam logic [FuncW-1:0] FuncDaa  = 5'd20;
  localparam logic [FuncW-1:0] FuncCpx  = 5'd21;
  localparam logic [FuncW-1:0] FuncLoad = 5'd22;

  localparam logic [7:0] DaaLimit  = 8'h99;
  localparam logic [7:0] DaaLowAdj = 8'h06;
  localparam logic [7:0] DaaHiAdj  = 8'h60;
  localparam logic [3:0] NibbleMax = 4'h9;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic             carry_in;
    logic             overflow_in;
    logic             half_in;
  } alu_req_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic             carry_out;
    logic             overflow_out;
    logic             zero_out;
    logic             negative_out;
    logic             half_out;
  } alu_res_t;

endpackage

>>> rtl/aluf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aluf_core
// Combinational datapath: one operation and its condition flags.
// ----------------------------------------------------------------------------
module aluf_core (
  input  aluf_pkg::alu_req_t req_i,
  output aluf_pkg::alu_res_t res_o
);

  logic [7:0] a, b, r, addend, x, y, incr;
  logic [8:0] s9;
  logic [4:0] s5;
  logic       ci, c, v, h, wide;
  logic [7:0] hi, lo;

  always_comb begin
    a      = req_i.operand_a[7:0];
    b      = req_i.operand_b[7:0];
    c      = req_i.carry_in;
    v      = req_i.overflow_in;
    h      = req_i.half_in;
    r      = 8'h00;
    wide   = 1'b0;
    addend = b;
    ci     = 1'b0;
    x      = a;
    y      = b;
    incr   = 8'h00;
    s9     = 9'h000;
    s5     = 5'h00;
    hi     = 8'h00;
    lo     = 8'h00;

    unique case (req_i.func) inside
      aluf_pkg::FuncAdd, aluf_pkg::FuncAdc, aluf_pkg::FuncInc: begin
        addend = (req_i.func == aluf_pkg::FuncInc) ? 8'h01 : b;
        ci     = (req_i.func == aluf_pkg::FuncAdc) ? req_i.carry_in : 1'b0;
        s9     = {1'b0, a} + {1'b0, addend} + {8'h00, ci};
        s5     = {1'b0, a[3:0]} + {1'b0, addend[3:0]} + {4'h0, ci};
        r      = s9[7:0];
        v      = (a[7] ~^ addend[7]) & (a[7] ^ r[7]);
        if (req_i.func != aluf_pkg::FuncInc) begin
          c = s9[8];
          h = s5[4];
        end
      end
      aluf_pkg::FuncSub, aluf_pkg::FuncSbc, aluf_pkg::FuncCmp,
      aluf_pkg::FuncNeg, aluf_pkg::FuncDec: begin
        if (req_i.func == aluf_pkg::FuncSbc) ci = req_i.carry_in;
        if (req_i.func == aluf_pkg::FuncNeg) begin
          x = 8'h00;
          y = a;
        end
        if (req_i.func == aluf_pkg::FuncDec) y = 8'h01;
        s9 = {1'b0, x} - {1'b0, y} - {8'h00, ci};
        r  = s9[7:0];
        v  = (x[7] ^ y[7]) & (x[7] ^ r[7]);
        if (req_i.func != aluf_pkg::FuncDec) c = s9[8];
      end
      aluf_pkg::FuncAnd, aluf_pkg::FuncBit: begin
        r = a & b;
        v = 1'b0;
      end
      aluf_pkg::FuncOr: begin
        r = a | b;
        v = 1'b0;
      end
      aluf_pkg::FuncEor: begin
        r = a ^ b;
        v = 1'b0;
      end
      aluf_pkg::FuncLsr: begin
        r = {1'b0, a[7:1]};
        c = a[0];
        v = r[7] ^ c;
      end
      aluf_pkg::FuncAsr: begin
        r = {a[7], a[7:1]};
        c = a[0];
        v = r[7] ^ c;
      end
      aluf_pkg::FuncAsl: begin
        r = {a[6:0], 1'b0};
        c = a[7];
        v = r[7] ^ c;
      end
      aluf_pkg::FuncRor: begin
        r = {req_i.carry_in, a[7:1]};
        c = a[0];
        v = r[7] ^ c;
      end
      aluf_pkg::FuncRol: begin
        r = {a[6:0], req_i.carry_in};
        c = a[7];
        v = r[7] ^ c;
      end
      aluf_pkg::FuncCom: begin
        r = ~a;
        c = 1'b1;
        v = 1'b0;
      end
      aluf_pkg::FuncClr: begin
        r = 8'h00;
        c = 1'b0;
        v = 1'b0;
      end
      aluf_pkg::FuncTst: begin
        r = a;
        c = 1'b0;
        v = 1'b0;
      end
      aluf_pkg::FuncDaa: begin
        if (req_i.half_in || (a[3:0] > aluf_pkg::NibbleMax)) incr = incr | aluf_pkg::DaaLowAdj;
        if (req_i.carry_in || (a > aluf_pkg::DaaLimit)) incr = incr | aluf_pkg::DaaHiAdj;
        r = a + incr;
        v = (a[7] ~^ incr[7]) & (a[7] ^ r[7]);
        c = req_i.carry_in | (a > aluf_pkg::DaaLimit);
      end
      aluf_pkg::FuncCpx: begin
        // Each byte is subtracted on its own; no borrow passes between them.
        wide = 1'b1;
        hi   = req_i.operand_a[15:8] - req_i.operand_b[15:8];
        lo   = req_i.operand_a[7:0] - req_i.operand_b[7:0];
        v    = (req_i.operand_a[15] ^ req_i.operand_b[15]) & (req_i.operand_a[15] ^ hi[7]);
      end
      default: begin
        // Load, and every unassigned code, passes the low byte of the first operand on.
        r = a;
        v = 1'b0;
      end
    endcase

    res_o.carry_out    = c;
    res_o.overflow_out = v;
    res_o.half_out     = h;
    if (wide) begin
      res_o.result       = {hi, lo};
      res_o.zero_out     = ({hi, lo} == 16'h0000);
      res_o.negative_out = hi[7];
    end else begin
      res_o.result       = {8'h00, r};
      res_o.zero_out     = (r == 8'h00);
      res_o.negative_out = r[7];
    end
  end

endmodule

>>> rtl/accumulator_alu_with_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags
// Eight-bit accumulator ALU with carry, overflow, zero, negative and
// half-carry flags, between an input register and a result register.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Carries
// s_axis    in         request: opcode in tuser, operands and incoming flags
// m_axis    out        result word and the five new flags
//
// One request is taken in every cycle while the output does not stall; the
// result passes from the input register through the datapath to the result
// register. Reset clears both valid flags only; the payload registers are
// not reset. When the output stalls, the result register holds and the
// input register still takes one more request before tready falls, so
// neither side waits while the other has room.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata fields from bit 0: operand_a[15:0], operand_b[31:16],
  // carry_in[32], overflow_in[33], half_in[34], zero fill [39:35].
  input  logic [aluf_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser fields from bit 0: func[4:0].
  input  logic [aluf_pkg::FuncW-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata fields from bit 0: result[15:0], carry_out[16], overflow_out[17],
  // zero_out[18], negative_out[19], half_out[20], zero fill [23:21].
  output logic [aluf_pkg::OutDataW-1:0]  m_axis_tdata
);

  // Input register stage.
  logic               req_valid_q;
  aluf_pkg::alu_req_t req_q, req_d;

  // Result register stage.
  logic               res_valid_q;
  aluf_pkg::alu_res_t res_q, res_d;

  logic res_ready, req_ready;

  // A stage can load when it is empty or its contents move on this cycle.
  assign res_ready     = !res_valid_q || m_axis_tready;
  assign req_ready     = !req_valid_q || res_ready;
  assign s_axis_tready = req_ready;

  always_comb begin
    req_d.func        = s_axis_tuser;
    req_d.operand_a   = s_axis_tdata[15:0];
    req_d.operand_b   = s_axis_tdata[31:16];
    req_d.carry_in    = s_axis_tdata[32];
    req_d.overflow_in = s_axis_tdata[33];
    req_d.half_in     = s_axis_tdata[34];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_ready) begin
      req_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready && s_axis_tvalid) begin
      req_q <= req_d;
    end
  end

  // The whole operation is worked out in one pass between the two registers.
  aluf_core u_core (
    .req_i (req_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.half_out, res_q.negative_out, res_q.zero_out,
                          res_q.overflow_out, res_q.carry_out, res_q.result};

  // An accepted request always lands in the input register.
  a_req_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> req_valid_q)
    else $error("accepted request not held in the input register");

  // A request waiting in the input register is not dropped by a stall.
  a_req_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !res_ready) |=> (req_valid_q && $stable(req_q)))
    else $error("stalled request lost or altered");

  // When the high byte is clear, the zero flag matches the low byte.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_q.result[15:8] == 8'h00)) |->
      (res_q.zero_out == (res_q.result[7:0] == 8'h00)))
    else $error("zero flag disagrees with result");

endmodule
